FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while reset is applied
`define QE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("quad overlap check failed");

// consequent a fixed number of cycles later, off while reset is applied
`define QE_ASSERT_DLY(lbl, clk, rstn, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##n (cons)) \
        else $error("quad overlap latency check failed");

// next-cycle implication, also checked during reset
`define QE_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("quad overlap reset check failed");

`endif

FILE: rtl/qeot_pkg.sv
package qeot_pkg;

    // port width of every coordinate field and register
    localparam int FIELD_W   = 32;
    // register index width, wide enough to see writes beyond the list
    localparam int CFG_IDX_W = 4;
    // corners per quadrilateral
    localparam int NUM_CORNERS = 4;
    // segment pairs tested per item
    localparam int NUM_PAIRS = NUM_CORNERS * NUM_CORNERS;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_X1 = 4'd0,
        REG_REF_X2 = 4'd1,
        REG_REF_X3 = 4'd2,
        REG_REF_X4 = 4'd3,
        REG_REF_Y1 = 4'd4,
        REG_REF_Y2 = 4'd5,
        REG_REF_Y3 = 4'd6,
        REG_REF_Y4 = 4'd7
    } t_cfg_reg;

endpackage

FILE: rtl/qeot_pair.sv
module qeot_pair #(
    parameter int DW = 33
) (
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_dxp,
    input  logic signed [DW-1:0] i_dyp,
    input  logic signed [DW-1:0] i_dxr,
    input  logic signed [DW-1:0] i_dyr,
    input  logic signed [DW-1:0] i_ex,
    input  logic signed [DW-1:0] i_ey,
    input  logic                 i_coll_touch,
    output logic                 o_hit
);

    localparam int PW = 2 * DW;

    logic signed [PW-1:0] r_c_den_a, r_c_den_b;
    logic signed [PW-1:0] r_c_na_a, r_c_na_b;
    logic signed [PW-1:0] r_c_nb_a, r_c_nb_b;
    logic                 r_c_coll;
    logic signed [PW-1:0] r_d_den, r_d_na, r_d_nb;
    logic                 r_d_coll;
    logic                 r_e_hit;
    logic                 n_e_hit;

    // strictly inside the open unit interval, den known nonzero
    function automatic logic open_unit(logic signed [PW-1:0] num,
                                       logic signed [PW-1:0] den);
        logic in_range;
        in_range = den[PW-1] ? (num > den) : (num < den);
        return (num != '0) && (num[PW-1] == den[PW-1]) && in_range;
    endfunction

    // cross product terms
    always_ff @(posedge i_clk) begin
        r_c_den_a <= PW'(i_dyr) * PW'(i_dxp);
        r_c_den_b <= PW'(i_dxr) * PW'(i_dyp);
        r_c_na_a  <= PW'(i_dxr) * PW'(i_ey);
        r_c_na_b  <= PW'(i_dyr) * PW'(i_ex);
        r_c_nb_a  <= PW'(i_dxp) * PW'(i_ey);
        r_c_nb_b  <= PW'(i_dyp) * PW'(i_ex);
        r_c_coll  <= i_coll_touch;
    end

    // denominator and numerators, exact
    always_ff @(posedge i_clk) begin
        r_d_den  <= r_c_den_a - r_c_den_b;
        r_d_na   <= r_c_na_a - r_c_na_b;
        r_d_nb   <= r_c_nb_a - r_c_nb_b;
        r_d_coll <= r_c_coll;
    end

    // crossing decision, parallel and collinear cases
    always_comb begin
        if (r_d_den == '0) begin
            n_e_hit = (r_d_na == '0) && r_d_coll;
        end else begin
            n_e_hit = open_unit(r_d_na, r_d_den) && open_unit(r_d_nb, r_d_den);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_hit <= n_e_hit;
    end

    assign o_hit = r_e_hit;

endmodule

FILE: rtl/quad_edge_overlap_test_top.sv
// channel   direction  handshake                  payload
// ---------------------------------------------------------------------------
// probe     in         start high, busy low       i_probe_corner1..4_x/_y
// result    out        o_valid, one-cycle strobe  o_overlap_hit
// config    in         i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// a probe transaction can be taken every cycle while busy is low; the result
// strobes after the six register stages (input, differences, products,
// cross-product sums, per-pair decision, or-reduce)
// synchronous active-low reset empties the pipeline and zeroes the
// reference corners; busy is high only while reset is applied
// no stall on either side: the receiver takes every result as it appears
module quad_edge_overlap_test_top #(
    parameter int COORD_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_probe_corner1_x,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_probe_corner2_x,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_probe_corner3_x,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_probe_corner4_x,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_probe_corner1_y,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_probe_corner2_y,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_probe_corner3_y,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_probe_corner4_y,
    input  logic                               i_cfg_wr_en,
    input  logic [qeot_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [qeot_pkg::FIELD_W-1:0]       i_cfg_wdata,
    output logic                               o_valid,
    output logic                               o_overlap_hit
);

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int NC = qeot_pkg::NUM_CORNERS;
    localparam int NP = qeot_pkg::NUM_PAIRS;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;

    logic [qeot_pkg::FIELD_W-1:0] r_ref_x [NC];
    logic [qeot_pkg::FIELD_W-1:0] r_ref_y [NC];
    logic [qeot_pkg::FIELD_W-1:0] w_in_x  [NC];
    logic [qeot_pkg::FIELD_W-1:0] w_in_y  [NC];
    t_coord                       w_rx    [NC];
    t_coord                       w_ry    [NC];

    logic   accept;
    logic   r_a_valid;
    t_coord r_a_px [NC];
    t_coord r_a_py [NC];

    logic   r_b_valid;
    t_diff  n_b_dxp [NC], r_b_dxp [NC];
    t_diff  n_b_dyp [NC], r_b_dyp [NC];
    t_diff  n_b_dxr [NC], r_b_dxr [NC];
    t_diff  n_b_dyr [NC], r_b_dyr [NC];
    t_diff  n_b_ex  [NP], r_b_ex  [NP];
    t_diff  n_b_ey  [NP], r_b_ey  [NP];
    logic   n_b_coll [NP], r_b_coll [NP];

    logic          r_c_valid, r_d_valid, r_e_valid;
    logic [NP-1:0] w_hit;
    logic          r_out_valid, r_out_hit;

    // collinear overlap on one axis: touching unless strictly apart
    function automatic logic span_touch(t_coord a1, t_coord a2,
                                        t_coord b1, t_coord b2);
        t_coord amax, amin, bmax, bmin;
        logic   apart;
        amax  = (a1 > a2) ? a1 : a2;
        amin  = (a1 < a2) ? a1 : a2;
        bmax  = (b1 > b2) ? b1 : b2;
        bmin  = (b1 < b2) ? b1 : b2;
        apart = ((a1 < b1) && (amax < bmin)) || ((b1 < a1) && (bmax < amin));
        return !apart;
    endfunction

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    assign w_in_x[0] = i_probe_corner1_x;
    assign w_in_x[1] = i_probe_corner2_x;
    assign w_in_x[2] = i_probe_corner3_x;
    assign w_in_x[3] = i_probe_corner4_x;
    assign w_in_y[0] = i_probe_corner1_y;
    assign w_in_y[1] = i_probe_corner2_y;
    assign w_in_y[2] = i_probe_corner3_y;
    assign w_in_y[3] = i_probe_corner4_y;

    // reference corner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NC; k++) begin
                r_ref_x[k] <= '0;
                r_ref_y[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (qeot_pkg::t_cfg_reg'(i_cfg_index))
                qeot_pkg::REG_REF_X1: r_ref_x[0] <= i_cfg_wdata;
                qeot_pkg::REG_REF_X2: r_ref_x[1] <= i_cfg_wdata;
                qeot_pkg::REG_REF_X3: r_ref_x[2] <= i_cfg_wdata;
                qeot_pkg::REG_REF_X4: r_ref_x[3] <= i_cfg_wdata;
                qeot_pkg::REG_REF_Y1: r_ref_y[0] <= i_cfg_wdata;
                qeot_pkg::REG_REF_Y2: r_ref_y[1] <= i_cfg_wdata;
                qeot_pkg::REG_REF_Y3: r_ref_y[2] <= i_cfg_wdata;
                qeot_pkg::REG_REF_Y4: r_ref_y[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // reference corners at coordinate width
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            w_rx[k] = t_coord'(r_ref_x[k][CW-1:0]);
            w_ry[k] = t_coord'(r_ref_y[k][CW-1:0]);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NC; k++) begin
            r_a_px[k] <= t_coord'(w_in_x[k][CW-1:0]);
            r_a_py[k] <= t_coord'(w_in_y[k][CW-1:0]);
        end
    end

    // edge vectors, corner offsets and collinear overlap per pair
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_b_dxp[i] = t_diff'(r_a_px[(i + 1) % NC]) - t_diff'(r_a_px[i]);
            n_b_dyp[i] = t_diff'(r_a_py[(i + 1) % NC]) - t_diff'(r_a_py[i]);
            n_b_dxr[i] = t_diff'(w_rx[(i + 1) % NC]) - t_diff'(w_rx[i]);
            n_b_dyr[i] = t_diff'(w_ry[(i + 1) % NC]) - t_diff'(w_ry[i]);
        end
        for (int i = 0; i < NC; i++) begin
            for (int j = 0; j < NC; j++) begin
                n_b_ex[i*NC+j] = t_diff'(r_a_px[i]) - t_diff'(w_rx[j]);
                n_b_ey[i*NC+j] = t_diff'(r_a_py[i]) - t_diff'(w_ry[j]);
                if (r_a_px[i] == r_a_px[(i + 1) % NC]) begin
                    n_b_coll[i*NC+j] = span_touch(r_a_py[i], r_a_py[(i + 1) % NC],
                                                  w_ry[j], w_ry[(j + 1) % NC]);
                end else begin
                    n_b_coll[i*NC+j] = span_touch(r_a_px[i], r_a_px[(i + 1) % NC],
                                                  w_rx[j], w_rx[(j + 1) % NC]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NC; k++) begin
            r_b_dxp[k] <= n_b_dxp[k];
            r_b_dyp[k] <= n_b_dyp[k];
            r_b_dxr[k] <= n_b_dxr[k];
            r_b_dyr[k] <= n_b_dyr[k];
        end
        for (int p = 0; p < NP; p++) begin
            r_b_ex[p]   <= n_b_ex[p];
            r_b_ey[p]   <= n_b_ey[p];
            r_b_coll[p] <= n_b_coll[p];
        end
    end

    // sixteen segment-pair pipelines
    for (genvar gi = 0; gi < NC; gi++) begin : g_probe_edge
        for (genvar gj = 0; gj < NC; gj++) begin : g_ref_edge
            qeot_pair #(
                .DW (DW)
            ) u_pair (
                .i_clk        (i_clk),
                .i_dxp        (r_b_dxp[gi]),
                .i_dyp        (r_b_dyp[gi]),
                .i_dxr        (r_b_dxr[gj]),
                .i_dyr        (r_b_dyr[gj]),
                .i_ex         (r_b_ex[gi*NC+gj]),
                .i_ey         (r_b_ey[gi*NC+gj]),
                .i_coll_touch (r_b_coll[gi*NC+gj]),
                .o_hit        (w_hit[gi*NC+gj])
            );
        end
    end

    // or-reduce into the output register
    always_ff @(posedge i_clk) begin
        r_out_hit <= |w_hit;
    end

    // valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= accept;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_overlap_hit = r_out_hit;

endmodule

FILE: rtl/qeot_checker.sv
`include "assert_macros.svh"

module qeot_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // every transaction taken gives a result once it has passed the pipeline
    `QE_ASSERT_DLY(a_latency, i_clk, i_rst_n, start && !busy, 6, o_valid)

    // no result without a transaction taken to match it
    `QE_ASSERT_IMP(a_no_orphan, i_clk, i_rst_n, o_valid, $past(start && !busy, 6))

    // reset flushes the result strobe
    `QE_ASSERT_NXT(a_reset_flush, i_clk, !i_rst_n, !o_valid)

    // outside reset the block never holds off a transaction
    `QE_ASSERT_IMP(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)

endmodule

bind quad_edge_overlap_test_top qeot_checker u_qeot_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
